FILE: rtl/tzda_pkg.sv
// Shared types, field widths and the month-length table for the time-zone date adjuster.
package tzda_pkg;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int WDAY_W   = 3;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;
	localparam int ZONE_W   = 5;

	localparam int TDATA_W  = 48;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	// Register index decoded from paddr[2].
	localparam logic REG_ZONE_OFFSET = 1'b0;

	// Quotient of year / 100 taken as (year * 5243) >> 19, exact for 14-bit years.
	localparam int QUOT_W       = 8;
	localparam int RECIP_100    = 5243;
	localparam int RECIP_SHIFT  = 19;
	localparam int RECIP_W      = 13;
	localparam int PROD_W       = YEAR_W + RECIP_W;

	localparam logic [4:0]         HOURS_PER_DAY = 5'd24;
	localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
	localparam logic [WDAY_W-1:0]  WDAY_SAT      = 3'd6;
	localparam logic [WDAY_W-1:0]  WDAY_SUN      = 3'd0;

	// Packed so that the last field (year) lands in the lowest bits.
	typedef struct packed {
		logic [SECOND_W-1:0] second;
		logic [MINUTE_W-1:0] minute;
		logic [HOUR_W-1:0]   hour;
		logic [WDAY_W-1:0]   wday;
		logic [DAY_W-1:0]    day;
		logic [MONTH_W-1:0]  month;
		logic [YEAR_W-1:0]   year;
	} in_item_t;

	typedef struct packed {
		logic                leap;
		logic [SECOND_W-1:0] second;
		logic [MINUTE_W-1:0] minute;
		logic [HOUR_W-1:0]   hour;
		logic [WDAY_W-1:0]   wday;
		logic [DAY_W-1:0]    day;
		logic [MONTH_W-1:0]  month;
		logic [YEAR_W-1:0]   year;
	} out_item_t;

	localparam int IN_ITEM_W  = $bits(in_item_t);
	localparam int OUT_ITEM_W = $bits(out_item_t);

	// Days in a month; codes outside 1..12 count as 31 days.
	function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (month)
			4'd2:    len = leap ? 5'd29 : 5'd28;
			4'd4:    len = 5'd30;
			4'd6:    len = 5'd30;
			4'd9:    len = 5'd30;
			4'd11:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

FILE: rtl/tzda_calc.sv
// Combinational hour shift with day, month, year and weekday carry or borrow.
module tzda_calc
	import tzda_pkg::*;
(
	input  in_item_t                  item,
	input  logic [QUOT_W-1:0]         year_div100,
	input  logic signed [ZONE_W-1:0]  zone_offset,
	output out_item_t                 result
);

	logic signed [HOUR_W+1:0] hour_sum;
	logic                     carry;
	logic                     borrow;
	logic [YEAR_W:0]          hundreds;
	logic                     div4;
	logic                     div100;
	logic                     leap;
	logic [DAY_W:0]           day_inc;
	logic [MONTH_W:0]         month_inc;
	logic [MONTH_W-1:0]       month_dec;

	assign hour_sum = $signed({2'b00, item.hour}) + (HOUR_W+2)'(zone_offset);
	assign carry    = hour_sum > $signed((HOUR_W+2)'(23));
	assign borrow   = hour_sum < $signed((HOUR_W+2)'(0));

	// Gregorian rule: divisible by 400, or by 4 and not by 100.
	assign hundreds = (YEAR_W+1)'(year_div100) * (YEAR_W+1)'(100);
	assign div4     = (item.year[1:0] == 2'b00);
	assign div100   = (hundreds == {1'b0, item.year});
	assign leap     = (div100 && (year_div100[1:0] == 2'b00)) || (!div100 && div4);

	assign day_inc   = {1'b0, item.day} + (DAY_W+1)'(1);
	assign month_inc = {1'b0, item.month} + (MONTH_W+1)'(1);
	assign month_dec = item.month - MONTH_W'(1);

	always_comb begin
		result        = '0;
		result.year   = item.year;
		result.month  = item.month;
		result.day    = item.day;
		result.wday   = item.wday;
		result.hour   = hour_sum[HOUR_W-1:0];
		result.minute = item.minute;
		result.second = item.second;
		result.leap   = leap;
		if (carry) begin
			result.hour = HOUR_W'(hour_sum - $signed({2'b00, HOURS_PER_DAY}));
			result.wday = (item.wday >= WDAY_SAT) ? WDAY_SUN : item.wday + WDAY_W'(1);
			if (day_inc > {1'b0, days_in(item.month, leap)}) begin
				result.day = DAY_W'(1);
				if (month_inc > {1'b0, MONTH_DEC}) begin
					result.month = MONTH_JAN;
					result.year  = item.year + YEAR_W'(1);
				end else begin
					result.month = month_inc[MONTH_W-1:0];
				end
			end else begin
				result.day = day_inc[DAY_W-1:0];
			end
		end else if (borrow) begin
			result.hour = HOUR_W'(hour_sum + $signed({2'b00, HOURS_PER_DAY}));
			result.wday = (item.wday == WDAY_SUN || item.wday > WDAY_SAT) ?
				WDAY_SAT : item.wday - WDAY_W'(1);
			if (item.day <= DAY_W'(1)) begin
				if (item.month == MONTH_JAN) begin
					result.year  = item.year - YEAR_W'(1);
					result.month = MONTH_DEC;
					result.day   = days_in(MONTH_DEC, leap);
				end else begin
					result.month = month_dec;
					result.day   = days_in(month_dec, leap);
				end
			end else begin
				result.day = item.day - DAY_W'(1);
			end
		end
	end

endmodule

FILE: rtl/timezone_date_adjust.sv
// Top level of the UTC to local time-zone date adjuster with its stream and register ports.
// Throughput is one transaction per cycle; the only limit is the output handshake.
// Stage one registers the input and the year / 100 quotient, stage two holds the result.
// Reset clears both stage valid flags and sets the zone offset register to zero.
// Register writes are expected only while no transaction is in flight.
module timezone_date_adjust
	import tzda_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// APB-style register port; register 0 (zone_offset_hours) at byte address 0.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	// Input stream.
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// From bit 0: utc_year[13:0], utc_month[17:14], utc_day[22:18], utc_weekday[25:23],
	// utc_hour[30:26], utc_minute[36:31], utc_second[42:37], zero fill [47:43].
	input  logic [TDATA_W-1:0] s_axis_tdata,
	// Output stream.
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// From bit 0: local_year[13:0], local_month[17:14], local_day[22:18],
	// local_weekday[25:23], local_hour[30:26], local_minute[36:31], local_second[42:37],
	// leap_flag[43], zero fill [47:44].
	output logic [TDATA_W-1:0] m_axis_tdata
);

	logic [ZONE_W-1:0] zone_q;

	logic              valid_s1;
	in_item_t          item_s1;
	logic [QUOT_W-1:0] quot_s1;
	logic              valid_s2;
	out_item_t         item_s2;

	logic              ready_s1;
	logic              ready_s2;
	logic              reg_sel;
	logic              reg_write;
	in_item_t          in_item;
	logic [PROD_W-1:0] recip_prod;
	out_item_t         calc_result;

	// The register index is the word address; low byte-address bits are ignored.
	assign reg_sel   = (paddr[2] == REG_ZONE_OFFSET);
	assign reg_write = psel && penable && pwrite && pready && reg_sel;
	assign pready    = 1'b1;
	assign prdata    = reg_sel ? PDATA_W'(zone_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= '0;
		end else if (reg_write) begin
			zone_q <= pwdata[ZONE_W-1:0];
		end
	end

	// A stage takes a new transaction when it is empty or its contents move on
	// in the same cycle; while a result waits, only an empty stage one takes input.
	assign ready_s2      = !valid_s2 || m_axis_tready;
	assign ready_s1      = !valid_s1 || ready_s2;
	assign s_axis_tready = ready_s1;

	assign in_item = in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]);

	// Year / 100 by reciprocal multiply; its product gets a register before
	// the multiply by 100 in the calendar logic.
	assign recip_prod = PROD_W'(in_item.year) * PROD_W'(RECIP_100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_axis_tvalid) begin
			item_s1 <= in_item;
			quot_s1 <= recip_prod[RECIP_SHIFT +: QUOT_W];
		end
		if (ready_s2 && valid_s1) begin
			item_s2 <= calc_result;
		end
	end

	// Hour shift and the one-day carry or borrow through the calendar.
	tzda_calc u_calc (
		.item        (item_s1),
		.year_div100 (quot_s1),
		.zone_offset ($signed(zone_q)),
		.result      (calc_result)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = TDATA_W'(item_s2);

endmodule

FILE: rtl/tzda_checker.sv
// Port-level checks for the time-zone date adjuster and their bind to the top level.
module tzda_checker
	import tzda_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tvalid,
	input logic               s_axis_tready,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [TDATA_W-1:0] m_axis_tdata
);

	// A stalled result keeps its data.
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// The corrected local hour always lies within one day.
	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[30:26] < 5'd24)
		else $error("local hour out of range");

	// An accepted transaction is followed by a valid result on the output.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
		else $error("result missing after accepted transaction");

	// Unused fill bits stay zero.
	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[47:44] == 4'd0)
		else $error("nonzero fill bits in result");

endmodule

bind timezone_date_adjust tzda_checker u_tzda_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

FILE: dv/timezone_date_adjust_test.sv
// Self-checking testbench for the UTC to local time-zone date adjuster.
`timescale 1ns / 100ps

import tzda_pkg::*;

// Scoreboard: predicts the local time for every accepted timestamp and checks results in order.
class tz_scoreboard;
	out_item_t local_times_due[$];
	int failures = 0;

	static function bit is_leap_year(logic [YEAR_W-1:0] year);
		int y;
		y = int'(year);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	static function int month_days(logic [MONTH_W-1:0] month, bit leap);
		case (month)
			MONTH_FEB:          return leap ? 29 : 28;
			4'd4, 4'd6, 4'd9, 4'd11: return 30;
			default:            return 31;
		endcase
	endfunction

	static function out_item_t to_local_time(in_item_t utc, logic [ZONE_W-1:0] zone);
		out_item_t loc;
		int offset;
		int hour;
		int next_day;
		int next_month;
		bit leap;
		leap = is_leap_year(utc.year);
		offset = int'(zone);
		if (offset >= 16)
			offset -= 32;
		hour = int'(utc.hour) + offset;
		loc.year   = utc.year;
		loc.month  = utc.month;
		loc.day    = utc.day;
		loc.wday   = utc.wday;
		loc.minute = utc.minute;
		loc.second = utc.second;
		loc.leap   = leap;
		if (hour > 23) begin
			hour -= 24;
			loc.wday = (utc.wday >= WDAY_SAT) ? WDAY_SUN : utc.wday + 1'b1;
			next_day = int'(utc.day) + 1;
			if (next_day > month_days(utc.month, leap)) begin
				loc.day = 5'd1;
				next_month = int'(utc.month) + 1;
				if (next_month > 12) begin
					loc.month = MONTH_JAN;
					loc.year = utc.year + 1'b1;
				end else begin
					loc.month = next_month[MONTH_W-1:0];
				end
			end else begin
				loc.day = next_day[DAY_W-1:0];
			end
		end else if (hour < 0) begin
			hour += 24;
			loc.wday = (utc.wday == WDAY_SUN || utc.wday > WDAY_SAT) ? WDAY_SAT
				: utc.wday - 1'b1;
			if (utc.day <= 5'd1) begin
				if (utc.month == MONTH_JAN) begin
					loc.year = utc.year - 1'b1;
					loc.month = MONTH_DEC;
				end else begin
					loc.month = utc.month - 1'b1;
				end
				loc.day = DAY_W'(month_days(loc.month, leap));
			end else begin
				loc.day = utc.day - 1'b1;
			end
		end
		loc.hour = hour[HOUR_W-1:0];
		return loc;
	endfunction

	function void note_input(in_item_t utc, logic [ZONE_W-1:0] zone);
		local_times_due.push_back(to_local_time(utc, zone));
	endfunction

	function void check_result(out_item_t got);
		out_item_t want;
		if (local_times_due.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("unexpected result: %0d-%0d-%0d wd%0d %0d:%0d:%0d leap %0d",
					got.year, got.month, got.day, got.wday, got.hour, got.minute,
					got.second, got.leap);
			return;
		end
		want = local_times_due.pop_front();
		if (got.year != want.year || got.month != want.month || got.day != want.day
			|| got.wday != want.wday || got.hour != want.hour
			|| got.minute != want.minute || got.second != want.second
			|| got.leap != want.leap) begin
			failures++;
			if (failures <= 10) begin
				$write("mismatch: expected %0d-%0d-%0d wd%0d %0d:%0d:%0d leap %0d,",
					want.year, want.month, want.day, want.wday, want.hour, want.minute,
					want.second, want.leap);
				$display(" got %0d-%0d-%0d wd%0d %0d:%0d:%0d leap %0d",
					got.year, got.month, got.day, got.wday,
					got.hour, got.minute, got.second, got.leap);
			end
		end
	endfunction
endclass

module timezone_date_adjust_test;

	logic               clk;
	logic               arst_n        = 1'b0;
	logic               psel          = 1'b0;
	logic               penable       = 1'b0;
	logic               pwrite        = 1'b0;
	logic [PADDR_W-1:0] paddr         = '0;
	logic [PDATA_W-1:0] pwdata        = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	// From bit 0: utc_year, utc_month, utc_day, utc_weekday, utc_hour, utc_minute,
	// utc_second, zero fill.
	logic [TDATA_W-1:0] s_axis_tdata  = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	// From bit 0: local_year, local_month, local_day, local_weekday, local_hour,
	// local_minute, local_second, leap_flag, zero fill.
	logic [TDATA_W-1:0] m_axis_tdata;

	// Zone offset the block currently holds; the reset value is zero hours.
	logic [ZONE_W-1:0]  zone_now = '0;
	// While set, neither side of the stream idles.
	bit                 calm = 1'b0;

	tz_scoreboard board = new();

	timezone_date_adjust uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard limit on the run, far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	// Sender gap in cycles: mostly back to back or short, now and then a long pause.
	function automatic int tx_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// Extra cycles the receiver keeps tready low once it decides to stall.
	function automatic int rx_stall();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(0, 2);
		return $urandom_range(10, 40);
	endfunction

	// The receiver alternates between open bursts and stalls of random length.
	// All handshake signals are sampled in the active region at the clock edge, so the
	// values seen are those that held right before the edge, as the block sees them.
	int rx_left = 0;
	bit rx_open = 1'b0;
	always @(posedge clk) begin
		if (calm) begin
			rx_open = 1'b1;
			rx_left = 0;
		end else if (rx_left > 0) begin
			rx_left--;
		end else begin
			rx_open = !rx_open;
			rx_left = rx_open ? $urandom_range(0, 24) : rx_stall();
		end
		m_axis_tready <= rx_open;
	end

	// Every result transaction is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tdata[OUT_ITEM_W-1:0]);
	end

	function automatic in_item_t stamp(int year, int month, int day, int wday, int hour,
		int minute, int second);
		in_item_t u;
		u.year   = year[YEAR_W-1:0];
		u.month  = month[MONTH_W-1:0];
		u.day    = day[DAY_W-1:0];
		u.wday   = wday[WDAY_W-1:0];
		u.hour   = hour[HOUR_W-1:0];
		u.minute = minute[MINUTE_W-1:0];
		u.second = second[SECOND_W-1:0];
		return u;
	endfunction

	// A tidy timestamp is a real calendar date, biased toward midnight and month ends so
	// that carries and borrows happen often. Otherwise every field spans its full width.
	function automatic in_item_t random_timestamp(bit tidy);
		int year;
		int month;
		int day;
		int len;
		int hour;
		if (!tidy)
			return stamp($urandom_range(0, 16383), $urandom_range(0, 15),
				$urandom_range(0, 31), $urandom_range(0, 7), $urandom_range(0, 31),
				$urandom_range(0, 63), $urandom_range(0, 63));
		if ($urandom_range(0, 99) < 60) begin
			year = $urandom_range(1, 9998);
		end else begin
			case ($urandom_range(0, 9))
				0: year = 1;
				1: year = 4;
				2: year = 100;
				3: year = 400;
				4: year = 1900;
				5: year = 2000;
				6: year = 2100;
				7: year = 2400;
				8: year = 9996;
				default: year = 9998;
			endcase
		end
		month = $urandom_range(1, 12);
		len = board.month_days(month[MONTH_W-1:0],
			board.is_leap_year(year[YEAR_W-1:0]));
		case ($urandom_range(0, 4))
			0: day = 1;
			1: day = len;
			2: day = len - 1;
			default: day = $urandom_range(1, len);
		endcase
		if ($urandom_range(0, 1))
			hour = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(21, 23);
		else
			hour = $urandom_range(0, 23);
		return stamp(year, month, day, $urandom_range(0, 6), hour, $urandom_range(0, 59),
			$urandom_range(0, 60));
	endfunction

	// Offers one timestamp after a random gap and returns at the edge that accepts it.
	// tvalid is left high so that a following item with no gap goes out back to back.
	task automatic send_timestamp(in_item_t utc);
		int gap;
		gap = tx_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(TDATA_W-IN_ITEM_W){1'b0}}, utc};
		do @(posedge clk); while (!s_axis_tready);
		board.note_input(utc, zone_now);
	endtask

	// Stops the sender and waits until every predicted result has been checked, then keeps
	// the clock running as a margin for the two-stage pipeline.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (board.local_times_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes the zone offset register through the APB port: setup phase, then access phase.
	// The register is only written while the pipeline is empty.
	task automatic set_zone(int hours);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_ZONE_OFFSET, 2'b00};
		pwdata <= PDATA_W'(hours);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		zone_now = hours[ZONE_W-1:0];
	endtask

	int zone_plan[8] = '{8, -1, 5, -7, 1, 0, 14, -12};
	int spin;

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, offset at its reset value of zero: all-low and all-high fields and a midday time with second 60.
		// Hour 31 with no offset still carries into the next day, and month 15 wraps the
		// year from 16383 to 0.
		send_timestamp(stamp(0, 1, 1, 0, 0, 0, 0));
		send_timestamp(stamp(16383, 15, 31, 7, 31, 63, 63));
		send_timestamp(stamp(2024, 6, 15, 3, 12, 30, 60));

		// Largest eastward offset: forward carries through month and year ends, leap rules,
		// out-of-range months, weekday 7 and days outside the month.
		set_zone(14);
		send_timestamp(stamp(9998, 12, 31, 4, 23, 59, 59));
		send_timestamp(stamp(16383, 12, 31, 6, 10, 0, 0));
		send_timestamp(stamp(2000, 2, 28, 1, 12, 0, 0));
		send_timestamp(stamp(1900, 2, 28, 3, 12, 0, 0));
		send_timestamp(stamp(2024, 2, 29, 4, 20, 0, 0));
		send_timestamp(stamp(2023, 13, 31, 2, 15, 1, 2));
		send_timestamp(stamp(2023, 0, 31, 5, 15, 0, 0));
		send_timestamp(stamp(2023, 0, 5, 7, 15, 0, 0));
		send_timestamp(stamp(2023, 4, 31, 1, 15, 0, 0));
		send_timestamp(stamp(2023, 7, 0, 2, 20, 0, 0));
		send_timestamp(stamp(2023, 5, 10, 3, 9, 0, 0));

		// Largest westward offset: borrows back through year 1 to 0 and year 0 to 16383,
		// into February of leap and common years, from month 0 and from day 0.
		set_zone(-12);
		send_timestamp(stamp(1, 1, 1, 0, 0, 0, 0));
		send_timestamp(stamp(0, 1, 1, 1, 5, 0, 0));
		send_timestamp(stamp(2000, 3, 1, 3, 11, 0, 0));
		send_timestamp(stamp(1900, 3, 1, 4, 11, 0, 0));
		send_timestamp(stamp(2023, 0, 1, 7, 3, 0, 0));
		send_timestamp(stamp(2023, 5, 0, 2, 0, 0, 0));
		send_timestamp(stamp(2023, 8, 31, 0, 6, 59, 60));
		send_timestamp(stamp(2023, 9, 15, 5, 31, 0, 0));
		send_timestamp(stamp(2023, 9, 15, 5, 12, 0, 0));
		send_timestamp(stamp(400, 3, 1, 1, 0, 0, 0));
		send_timestamp(stamp(2100, 3, 1, 1, 0, 0, 0));

		// Random part: one zone setting per phase, most items real dates, the rest noise.
		// One phase runs with no idling at all, and one has the sender hold off mid-phase
		// until every result is back.
		zone_plan[4] = $urandom_range(0, 26) - 12;
		for (int phase = 0; phase < 8; phase++) begin
			set_zone(zone_plan[phase]);
			calm = (phase == 5);
			for (int n = 0; n < 88; n++) begin
				if (phase == 2 && n == 40)
					wait_drained();
				send_timestamp(random_timestamp($urandom_range(0, 99) < 75));
			end
		end
		calm = 1'b0;

		// Drain: wait for every result, up to a bound, then keep the clock running to catch strays.
		s_axis_tvalid <= 1'b0;
		spin = 0;
		while (board.local_times_due.size() != 0 && spin < 5000) begin
			@(posedge clk);
			spin++;
		end
		repeat (10) @(posedge clk);

		if (board.failures == 0 && board.local_times_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
rtl/tzda_pkg.sv
rtl/tzda_calc.sv
rtl/timezone_date_adjust.sv
rtl/tzda_checker.sv
dv/timezone_date_adjust_test.sv
